### src/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
`default_nettype none
package bba_pkg;
  localparam int unsigned MinBlockBytes = 64;
  localparam int unsigned MinShift      = 6;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_FREE = 2'd1,
    ST_USED = 2'd2
  } unit_st_e;

  localparam logic [1:0] RES_ALLOCATED = 2'd0;
  localparam logic [1:0] RES_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] RES_FREED = 2'd2;
  localparam logic [1:0] RES_FREE_REJECT = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
endpackage
`default_nettype wire

### src/bba_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/buddy_block_allocator.sv
// Top level of the buddy block allocator: sequencer over shared unit memories.
//
//  channel | signals                                        | direction
//  request | start_i, busy_o, command_i, request_bytes_i,   | in
//          | user_offset_i                                  |
//  result  | done_o, status_o, granted_offset_o,            | out
//          | granted_level_o, used_bytes_o                  |
//
// An allocate rounds the size up one level at a time, walks up the lists to the
// first non-empty one, pops its head, splits one level down per step (with a further
// step to fix a prev link when the lower list was not empty) and finishes. A free
// checks the offset and reads the unit, tests each buddy in turn and pushes the
// merged block, with a further step when that list was not empty. Every list step
// waits on the registered read of the unit memories. After reset a clearing pass
// sweeps the unit memories while busy_o is high. The result is shown for one cycle
// on done_o, in the first idle cycle, and the receiver cannot stall it.
`default_nettype none
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned POOL_ORDER   = 10,
  parameter int unsigned LEVEL_COUNT  = 16,
  parameter int unsigned HEADER_BYTES = 40
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [23:0] request_bytes_i,
  input  wire logic [15:0] user_offset_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [15:0]      granted_offset_o,
  output logic [3:0]       granted_level_o,
  output logic [16:0]      used_bytes_o
);
  localparam int unsigned TopLevel = (POOL_ORDER < LEVEL_COUNT) ? POOL_ORDER
                                                                : LEVEL_COUNT - 1;
  localparam int unsigned UnitCount = 1 << TopLevel;
  localparam int unsigned UW = TopLevel;       // unit index width
  localparam int unsigned LW = UW + 1;         // link width, value UnitCount = none
  localparam int unsigned MetaW = 6;           // status and level per unit
  localparam logic [LW-1:0] LinkNone = LW'(UnitCount);
  localparam logic [3:0] TopLv = 4'(TopLevel);
  localparam logic [25:0] PoolBytes = 26'(MinBlockBytes) << TopLevel;

  typedef struct packed {
    unit_st_e   st;
    logic [3:0] lv;
  } meta_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SIZE, S_SEARCH, S_POP, S_SPLIT, S_SPLIT_P, S_FCHK,
    S_FTEST, S_MERGE, S_MTEST, S_PUSH, S_PUSH_P
  } state_e;

  state_e           state_q;
  logic [UW-1:0]    clr_q;
  logic [3:0]       lv_q, s_q;
  logic [UW-1:0]    u_q;
  logic [LW-1:0]    heads_q [16];   // list heads, one per 4-bit level
  logic [16:0]      used_q;
  logic [23:0]      req_q;
  logic [15:0]      off_q;
  logic [LW-1:0]    lnk_q;          // old list head whose prev link gets fixed

  // unit memory ports
  logic              meta_we;
  logic [UW-1:0]     meta_waddr, meta_raddr;
  meta_t             meta_wdata, meta_rdata;
  logic [MetaW-1:0]  meta_rdata_raw;
  logic              nxt_we;
  logic [UW-1:0]     nxt_waddr, nxt_raddr;
  logic [LW-1:0]     nxt_wdata, nxt_rdata;
  logic              prv_we;
  logic [UW-1:0]     prv_waddr, prv_raddr;
  logic [LW-1:0]     prv_wdata, prv_rdata;

  bba_ram #(.Width(MetaW), .Depth(UnitCount)) u_meta (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(meta_raddr),
    .rdata_o(meta_rdata_raw)
  );
  assign meta_rdata = meta_t'(meta_rdata_raw);

  bba_ram #(.Width(LW), .Depth(UnitCount)) u_next (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(nxt_waddr),
    .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr),
    .rdata_o(nxt_rdata)
  );

  bba_ram #(.Width(LW), .Depth(UnitCount)) u_prev (
    .clk_i  (clk_i),
    .we_i   (prv_we),
    .waddr_i(prv_waddr),
    .wdata_i(prv_wdata),
    .raddr_i(prv_raddr),
    .rdata_o(prv_rdata)
  );

  logic [24:0]         need;
  logic [25:0]         blk_bytes;
  logic [LW-1:0]       head_s, head_lv, head_dn;
  logic [3:0]          s_dn;
  logic [UW-1:0]       split_u;   // upper half pushed by a split
  logic [UW-1:0]       half_u;    // upper half after the split step
  logic [UW-1:0]       buddy;
  logic [15:0]         start_off;
  logic [15-MinShift:0] start_unit;
  logic                bad_off;
  logic [3:0]          fr_lv;
  logic [25:0]         fr_bytes;
  logic                merge_ok;

  assign need       = 25'(req_q) + 25'(HEADER_BYTES);
  assign blk_bytes  = 26'(MinBlockBytes) << lv_q;
  assign head_s     = heads_q[s_q];
  assign head_lv    = heads_q[lv_q];
  assign s_dn       = s_q - 4'd1;
  assign head_dn    = heads_q[s_dn];
  assign split_u    = u_q + (UW'(1) << s_dn);
  assign half_u     = u_q + (UW'(1) << s_q);
  assign buddy      = u_q ^ (UW'(1) << lv_q);
  assign start_off  = off_q - 16'(HEADER_BYTES);
  assign start_unit = start_off[15:MinShift];
  assign bad_off    = (off_q < 16'(HEADER_BYTES)) || (start_off[MinShift-1:0] != '0) ||
                      (32'(start_unit) >= UnitCount);
  assign fr_lv      = (meta_rdata.lv > TopLv) ? TopLv : meta_rdata.lv;
  assign fr_bytes   = 26'(MinBlockBytes) << fr_lv;
  assign merge_ok   = (meta_rdata.st == ST_FREE) && (meta_rdata.lv == lv_q);

  // steer the unit memory ports
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = u_q;
    meta_wdata = '{st: ST_NONE, lv: 4'd0};
    meta_raddr = u_q;
    nxt_we     = 1'b0;
    nxt_waddr  = u_q;
    nxt_wdata  = LinkNone;
    nxt_raddr  = u_q;
    prv_we     = 1'b0;
    prv_waddr  = u_q;
    prv_wdata  = LinkNone;
    prv_raddr  = u_q;
    unique case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        if (clr_q == '0) begin
          meta_wdata = '{st: ST_FREE, lv: TopLv};
        end
        nxt_we     = 1'b1;
        nxt_waddr  = clr_q;
        prv_we     = 1'b1;
        prv_waddr  = clr_q;
      end
      S_SEARCH: nxt_raddr = head_s[UW-1:0];
      S_POP: begin
        if (nxt_rdata != LinkNone) begin
          prv_we    = 1'b1;
          prv_waddr = nxt_rdata[UW-1:0];
        end
      end
      S_SPLIT: begin
        meta_we = 1'b1;
        if (s_q == lv_q) begin
          meta_wdata = '{st: ST_USED, lv: lv_q};
        end else begin
          meta_waddr = split_u;
          meta_wdata = '{st: ST_FREE, lv: s_dn};
          nxt_we     = 1'b1;
          nxt_waddr  = split_u;
          nxt_wdata  = head_dn;
          prv_we     = 1'b1;
          prv_waddr  = split_u;
        end
      end
      S_SPLIT_P: begin
        prv_we    = 1'b1;
        prv_waddr = lnk_q[UW-1:0];
        prv_wdata = LW'(half_u);
      end
      S_FCHK: meta_raddr = UW'(start_unit);
      S_FTEST: begin
        meta_we = (meta_rdata.st == ST_USED);
      end
      S_MERGE: begin
        meta_raddr = buddy;
        nxt_raddr  = buddy;
        prv_raddr  = buddy;
      end
      S_MTEST: begin
        if (merge_ok) begin
          meta_we    = 1'b1;
          meta_waddr = buddy;
          if (prv_rdata != LinkNone) begin
            nxt_we    = 1'b1;
            nxt_waddr = prv_rdata[UW-1:0];
            nxt_wdata = nxt_rdata;
          end
          if (nxt_rdata != LinkNone) begin
            prv_we    = 1'b1;
            prv_waddr = nxt_rdata[UW-1:0];
            prv_wdata = prv_rdata;
          end
        end
      end
      S_PUSH: begin
        meta_we    = 1'b1;
        meta_wdata = '{st: ST_FREE, lv: lv_q};
        nxt_we     = 1'b1;
        nxt_wdata  = head_lv;
        prv_we     = 1'b1;
      end
      S_PUSH_P: begin
        prv_we    = 1'b1;
        prv_waddr = lnk_q[UW-1:0];
        prv_wdata = LW'(u_q);
      end
      default: ;
    endcase
  end

  // sequencer and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      lv_q     <= '0;
      s_q      <= '0;
      u_q      <= '0;
      used_q   <= '0;
      req_q    <= '0;
      off_q    <= '0;
      lnk_q    <= LinkNone;
      done_o   <= 1'b0;
      status_o <= RES_ALLOCATED;
      granted_offset_o <= '0;
      granted_level_o  <= '0;
      for (int i = 0; i < 16; i++) begin
        heads_q[i] <= (i == int'(TopLevel)) ? LW'(0) : LinkNone;
      end
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        // sweep the unit memories once
        S_CLEAR: begin
          clr_q <= clr_q + UW'(1);
          if (clr_q == UW'(UnitCount - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            req_q   <= request_bytes_i;
            off_q   <= user_offset_i;
            lv_q    <= '0;
            state_q <= (command_i == CMD_ALLOC) ? S_SIZE : S_FCHK;
          end
        end
        // round up one level per cycle
        S_SIZE: begin
          if (req_q == '0 || 26'(req_q) > PoolBytes || (26'(need) > blk_bytes &&
              lv_q == TopLv)) begin
            status_o         <= RES_ALLOC_FAIL;
            granted_offset_o <= '0;
            granted_level_o  <= '0;
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
          end else if (26'(need) <= blk_bytes) begin
            s_q     <= lv_q;
            state_q <= S_SEARCH;
          end else begin
            lv_q <= lv_q + 4'd1;
          end
        end
        // walk up to the first non-empty list
        S_SEARCH: begin
          if (head_s != LinkNone) begin
            u_q     <= head_s[UW-1:0];
            state_q <= S_POP;
          end else if (s_q == TopLv) begin
            status_o         <= RES_ALLOC_FAIL;
            granted_offset_o <= '0;
            granted_level_o  <= '0;
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
          end else begin
            s_q <= s_q + 4'd1;
          end
        end
        // pop the head, its successor becomes head
        S_POP: begin
          heads_q[s_q] <= nxt_rdata;
          state_q      <= S_SPLIT;
        end
        // push the upper half one level down, or grant the block
        S_SPLIT: begin
          if (s_q == lv_q) begin
            used_q           <= used_q + 17'(blk_bytes);
            status_o         <= RES_ALLOCATED;
            granted_offset_o <= 16'(32'(u_q) << MinShift) + 16'(HEADER_BYTES);
            granted_level_o  <= lv_q;
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
          end else begin
            heads_q[s_dn] <= LW'(split_u);
            lnk_q         <= head_dn;
            s_q           <= s_dn;
            state_q       <= (head_dn != LinkNone) ? S_SPLIT_P : S_SPLIT;
          end
        end
        S_SPLIT_P: state_q <= S_SPLIT;
        // check the offset, read the unit
        S_FCHK: begin
          if (bad_off) begin
            status_o         <= RES_FREE_REJECT;
            granted_offset_o <= '0;
            granted_level_o  <= '0;
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
          end else begin
            u_q     <= UW'(start_unit);
            state_q <= S_FTEST;
          end
        end
        // accept only an allocated block start
        S_FTEST: begin
          if (meta_rdata.st != ST_USED) begin
            status_o         <= RES_FREE_REJECT;
            granted_offset_o <= '0;
            granted_level_o  <= '0;
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
          end else begin
            lv_q    <= fr_lv;
            used_q  <= (26'(used_q) >= fr_bytes) ? used_q - 17'(fr_bytes) : '0;
            state_q <= S_MERGE;
          end
        end
        S_MERGE: state_q <= (lv_q == TopLv) ? S_PUSH : S_MTEST;
        // unlink a free buddy and climb one level
        S_MTEST: begin
          if (merge_ok) begin
            if (prv_rdata == LinkNone) heads_q[lv_q] <= nxt_rdata;
            if (buddy < u_q) u_q <= buddy;
            lv_q    <= lv_q + 4'd1;
            state_q <= S_MERGE;
          end else begin
            state_q <= S_PUSH;
          end
        end
        // push the merged block
        S_PUSH: begin
          heads_q[lv_q] <= LW'(u_q);
          lnk_q         <= head_lv;
          if (head_lv != LinkNone) begin
            state_q <= S_PUSH_P;
          end else begin
            status_o         <= RES_FREED;
            granted_offset_o <= '0;
            granted_level_o  <= '0;
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        S_PUSH_P: begin
          status_o         <= RES_FREED;
          granted_offset_o <= '0;
          granted_level_o  <= '0;
          done_o           <= 1'b1;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign used_bytes_o = used_q;

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o);
  // a result is shown while idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o);
  // an accepted request makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o);
  // results other than a grant carry zero offset and level
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != RES_ALLOCATED) |->
    (granted_offset_o == '0 && granted_level_o == '0));
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps
module testbench
  import bba_pkg::*;
();

  localparam int unsigned PoolOrder   = 10;
  localparam int unsigned LevelCount  = 16;
  localparam int unsigned HeaderBytes = 40;
  localparam int unsigned TopLevel    = (PoolOrder < LevelCount) ? PoolOrder : LevelCount - 1;
  localparam int unsigned UnitCount   = 1 << TopLevel;
  localparam int unsigned PoolBytes   = MinBlockBytes << TopLevel;
  localparam int unsigned LinkNone    = UnitCount;
  localparam int unsigned RandomItems = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [3:0]  level;
    logic [16:0] used;
  } alloc_result_t;

  typedef struct {
    logic        command;
    logic [23:0] request_bytes;
    logic [15:0] user_offset;
    bit          typed;
    logic [1:0]  status;
    logic [3:0]  level;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        command_i;
  logic [23:0] request_bytes_i;
  logic [15:0] user_offset_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] granted_offset_o;
  logic [3:0]  granted_level_o;
  logic [16:0] used_bytes_o;

  // Shadow allocator state
  unit_st_e    blk_state [UnitCount];
  int unsigned blk_level [UnitCount];
  int unsigned blk_next [UnitCount];
  int unsigned blk_prev [UnitCount];
  int unsigned free_head [LevelCount];
  int unsigned used_sum;

  alloc_result_t expected_q[$];
  logic [15:0]   live_offsets[$];
  bit            failed;

  buddy_block_allocator #(
    .POOL_ORDER  (PoolOrder),
    .LEVEL_COUNT (LevelCount),
    .HEADER_BYTES(HeaderBytes)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .request_bytes_i (request_bytes_i),
    .user_offset_i   (user_offset_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_offset_o(granted_offset_o),
    .granted_level_o (granted_level_o),
    .used_bytes_o    (used_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAIL buddy_block_allocator");
    $finish;
  end

  function automatic void push_free(int unsigned lv, int unsigned u);
    int unsigned h;
    h = free_head[lv];
    blk_next[u] = h;
    blk_prev[u] = LinkNone;
    if (h < UnitCount) blk_prev[h] = u;
    free_head[lv] = u;
    blk_state[u] = ST_FREE;
    blk_level[u] = lv;
  endfunction

  function automatic void unlink_free(int unsigned lv, int unsigned u);
    int unsigned p, n;
    p = blk_prev[u];
    n = blk_next[u];
    if (p < UnitCount) blk_next[p] = n;
    else free_head[lv] = n;
    if (n < UnitCount) blk_prev[n] = p;
    blk_next[u] = LinkNone;
    blk_prev[u] = LinkNone;
  endfunction

  function automatic void clear_pool();
    for (int unsigned i = 0; i < UnitCount; i++) begin
      blk_state[i] = ST_NONE;
      blk_level[i] = 0;
      blk_next[i]  = LinkNone;
      blk_prev[i]  = LinkNone;
    end
    for (int unsigned i = 0; i < LevelCount; i++) free_head[i] = LinkNone;
    used_sum = 0;
    push_free(TopLevel, 0);
  endfunction

  // Advance the shadow allocator by one request and return its result
  function automatic alloc_result_t apply_request(logic cmd, logic [23:0] req,
                                                  logic [15:0] uoff);
    alloc_result_t r;
    longint unsigned need;
    int unsigned lv, s, u, b, start, size;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      r.status = RES_ALLOC_FAIL;
      if (req == 0 || req > PoolBytes) begin
        r.used = used_sum[16:0];
        return r;
      end
      need = longint'(req) + HeaderBytes;
      lv = 0;
      while (lv <= TopLevel && (longint'(MinBlockBytes) << lv) < need) lv++;
      s = lv;
      while (s <= TopLevel && free_head[s] >= UnitCount) s++;
      if (lv > TopLevel || s > TopLevel) begin
        r.used = used_sum[16:0];
        return r;
      end
      u = free_head[s];
      unlink_free(s, u);
      while (s > lv) begin
        s--;
        push_free(s, u + (1 << s));
      end
      blk_state[u] = ST_USED;
      blk_level[u] = lv;
      used_sum = (used_sum + (MinBlockBytes << lv)) & 'h1FFFF;
      r.status = RES_ALLOCATED;
      r.offset = 16'(u * MinBlockBytes + HeaderBytes);
      r.level  = 4'(lv);
    end else begin
      r.status = RES_FREE_REJECT;
      start = uoff - HeaderBytes;
      u = start / MinBlockBytes;
      if (uoff < HeaderBytes || start % MinBlockBytes != 0 || u >= UnitCount
          || blk_state[u] != ST_USED) begin
        r.used = used_sum[16:0];
        return r;
      end
      lv = blk_level[u];
      if (lv > TopLevel) lv = TopLevel;
      size = MinBlockBytes << lv;
      used_sum = (used_sum >= size) ? used_sum - size : 0;
      blk_state[u] = ST_NONE;
      while (lv < TopLevel) begin
        b = u ^ (1 << lv);
        if (blk_state[b] != ST_FREE || blk_level[b] != lv) break;
        unlink_free(lv, b);
        blk_state[b] = ST_NONE;
        blk_level[b] = 0;
        blk_level[u] = 0;
        if (b < u) u = b;
        lv++;
      end
      push_free(lv, u);
      r.status = RES_FREED;
    end
    r.used = used_sum[16:0];
    return r;
  endfunction

  // Hold the inputs idle for a random gap, mostly short
  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  // Drive one request and wait for its acceptance
  task automatic send_request(logic cmd, logic [23:0] req, logic [15:0] uoff,
                              bit typed, logic [1:0] t_status, logic [3:0] t_level);
    alloc_result_t r;
    start_i         = 1'b1;
    command_i       = cmd;
    request_bytes_i = req;
    user_offset_i   = uoff;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = apply_request(cmd, req, uoff);
    if (typed && r.status != t_status) begin
      $error("status: expected %0d actual %0d", t_status, r.status);
      failed = 1'b1;
    end
    if (typed && r.level != t_level) begin
      $error("granted_level: expected %0d actual %0d", t_level, r.level);
      failed = 1'b1;
    end
    if (typed) begin
      r.status = t_status;
      r.level  = t_level;
    end
    if (r.status == RES_ALLOCATED) live_offsets.push_back(r.offset);
    if (cmd == CMD_FREE)
      foreach (live_offsets[i])
        if (live_offsets[i] == uoff && r.status == RES_FREED) begin
          live_offsets.delete(i);
          break;
        end
    expected_q.push_back(r);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Check each strobed result against the oldest expectation
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o);
          failed = 1'b1;
        end
        if (granted_offset_o !== e.offset) begin
          $error("granted_offset: expected %0d actual %0d", e.offset, granted_offset_o);
          failed = 1'b1;
        end
        if (granted_level_o !== e.level) begin
          $error("granted_level: expected %0d actual %0d", e.level, granted_level_o);
          failed = 1'b1;
        end
        if (used_bytes_o !== e.used) begin
          $error("used_bytes: expected %0d actual %0d", e.used, used_bytes_o);
          failed = 1'b1;
        end
      end
    end
  end

  stim_row_t   directed[$];
  int unsigned pick, wait_cycles;
  logic [15:0] uoff;
  logic [23:0] req;

  initial begin
    failed          = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    command_i       = CMD_ALLOC;
    request_bytes_i = '0;
    user_offset_i   = '0;
    clear_pool();

    // Directed rows: typed results only where obvious
    directed = '{
      '{CMD_FREE,  24'd0,        16'd40,     1, RES_FREE_REJECT, 4'd0},
      '{CMD_ALLOC, 24'd0,        16'd0,      1, RES_ALLOC_FAIL,  4'd0},
      '{CMD_ALLOC, 24'hFFFFFF,   16'hFFFF,   1, RES_ALLOC_FAIL,  4'd0},
      '{CMD_ALLOC, 24'd65536,    16'd0,      1, RES_ALLOC_FAIL,  4'd0},
      '{CMD_ALLOC, 24'd65497,    16'd0,      1, RES_ALLOC_FAIL,  4'd0},
      '{CMD_ALLOC, 24'd65496,    16'd0,      1, RES_ALLOCATED,   4'd10},
      '{CMD_ALLOC, 24'd1,        16'd0,      1, RES_ALLOC_FAIL,  4'd0},
      '{CMD_FREE,  24'd0,        16'd40,     1, RES_FREED,       4'd0},
      '{CMD_FREE,  24'd0,        16'd40,     1, RES_FREE_REJECT, 4'd0},
      '{CMD_ALLOC, 24'd1,        16'd0,      1, RES_ALLOCATED,   4'd0},
      '{CMD_ALLOC, 24'd24,       16'd0,      0, RES_ALLOCATED,   4'd0},
      '{CMD_ALLOC, 24'd25,       16'd0,      0, RES_ALLOCATED,   4'd0},
      '{CMD_ALLOC, 24'd4000,     16'd0,      0, RES_ALLOCATED,   4'd0},
      '{CMD_FREE,  24'hFFFFFF,   16'd0,      1, RES_FREE_REJECT, 4'd0},
      '{CMD_FREE,  24'd0,        16'd41,     1, RES_FREE_REJECT, 4'd0},
      '{CMD_FREE,  24'd0,        16'hFFFF,   1, RES_FREE_REJECT, 4'd0},
      '{CMD_FREE,  24'd0,        16'd65448,  1, RES_FREE_REJECT, 4'd0},
      '{CMD_FREE,  24'd0,        16'd104,    0, RES_FREED,       4'd0},
      '{CMD_FREE,  24'd0,        16'd40,     0, RES_FREED,       4'd0},
      '{CMD_FREE,  24'd0,        16'd168,    0, RES_FREED,       4'd0},
      '{CMD_FREE,  24'd0,        16'd296,    0, RES_FREED,       4'd0},
      '{CMD_FREE,  24'd0,        16'd4136,   0, RES_FREED,       4'd0}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      send_request(directed[i].command, directed[i].request_bytes, directed[i].user_offset,
                   directed[i].typed, directed[i].status, directed[i].level);
      idle_gap();
    end

    // Random mix: mostly valid alloc/free pairs, some malformed requests
    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0: req = 24'($urandom_range(1, 24));
          1: req = 24'($urandom_range(1, 1000));
          2: req = 24'($urandom_range(1, 8000));
          default: req = 24'($urandom_range(1, PoolBytes));
        endcase
        send_request(CMD_ALLOC, req, 16'($urandom), 0, RES_ALLOCATED, 4'd0);
      end else if (pick < 85 && live_offsets.size() > 0) begin
        uoff = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        send_request(CMD_FREE, 24'($urandom), uoff, 0, RES_FREED, 4'd0);
      end else if (pick < 92) begin
        send_request(CMD_ALLOC, 24'($urandom), 16'($urandom), 0, RES_ALLOCATED, 4'd0);
      end else begin
        uoff = ($urandom_range(0, 1) == 0) ? 16'($urandom)
             : 16'($urandom_range(0, UnitCount - 1) * MinBlockBytes + HeaderBytes);
        send_request(CMD_FREE, 24'($urandom), uoff, 0, RES_FREED, 4'd0);
      end
      idle_gap();
    end

    // Drain outstanding results, then allow the block to settle
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("PASS buddy_block_allocator");
    end else begin
      $display("FAIL buddy_block_allocator");
    end
    $finish;
  end
endmodule

### buddy_block_allocator.f
src/bba_pkg.sv
src/bba_ram.sv
src/buddy_block_allocator.sv
verif/testbench.sv
